FILE: rtl/core/bsmh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the box stacking block.
// No dependencies; every other file but bsmh_ram imports this package.
package bsmh_pkg;

	localparam int FIELD_W  = 16;
	localparam int HEIGHT_W = 23;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 23'h7FFFFF;

	typedef struct packed {
		logic [FIELD_W-1:0] dim_x;
		logic [FIELD_W-1:0] dim_y;
		logic [FIELD_W-1:0] dim_z;
		logic               last_box;
	} box_beat_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] max_height;
		logic                overflowed;
	} result_beat_t;

	// loader status seen by the top level
	typedef struct packed {
		logic busy;
		logic go;
		logic overflow;
	} load_stat_t;

	// finished stack height offered by the chain engine
	typedef struct packed {
		logic                valid;
		logic [HEIGHT_W-1:0] height;
	} chain_res_t;

endpackage

FILE: rtl/core/bsmh_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/bsmh_load.sv
`timescale 1ns / 1ps
// Box loader: sorts one box's sides and writes its three orientations.
// Depends on bsmh_pkg.
module bsmh_load #(
	parameter int CAP = 96,
	parameter int DW  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [DW-1:0]              dx,
	input  logic [DW-1:0]              dy,
	input  logic [DW-1:0]              dz,
	input  logic                       last,
	input  logic                       clear,
	output bsmh_pkg::load_stat_t       stat,
	output logic [$clog2(CAP+1)-1:0]   count,
	output logic                       we,
	output logic [$clog2(CAP)-1:0]     waddr,
	output logic [3*DW-1:0]            wdata
);
	import bsmh_pkg::*;

	localparam int CW = $clog2(CAP + 1);
	localparam int AW = $clog2(CAP);

	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_C = 2'd2;

	logic [DW-1:0] s0, s1, s2, t0, t1, t2;
	logic [DW-1:0] lo_q, mid_q, hi_q;
	logic [1:0]    phase_q;
	logic          busy_q, fit_q, last_q, go_q, ovf_q;
	logic [CW-1:0] count_q;
	logic          fit;

	// three compare-swap steps
	always_comb begin
		t0 = (dx > dy) ? dy : dx;
		t1 = (dx > dy) ? dx : dy;
		t2 = dz;
		s2 = (t1 > t2) ? t1 : t2;
		t1 = (t1 > t2) ? t2 : t1;
		s0 = (t0 > t1) ? t1 : t0;
		s1 = (t0 > t1) ? t0 : t1;
	end

	assign fit = ({1'b0, count_q} + (CW+1)'(3)) <= (CW+1)'(CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_A;
			fit_q   <= 1'b0;
			last_q  <= 1'b0;
			go_q    <= 1'b0;
			ovf_q   <= 1'b0;
			count_q <= '0;
		end else begin
			go_q <= 1'b0;
			if (clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (take) begin
				busy_q  <= 1'b1;
				phase_q <= PH_A;
				fit_q   <= fit;
				last_q  <= last;
				if (!fit) begin
					ovf_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (fit_q) begin
					count_q <= count_q + CW'(1);
				end
				if (phase_q == PH_C) begin
					busy_q <= 1'b0;
					go_q   <= last_q;
				end
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lo_q  <= s0;
			mid_q <= s1;
			hi_q  <= s2;
		end
	end

	// orientation word: {height, short side, long side}
	always_comb begin
		case (phase_q)
			PH_A:    wdata = {lo_q, mid_q, hi_q};
			PH_B:    wdata = {mid_q, lo_q, hi_q};
			default: wdata = {hi_q, lo_q, mid_q};
		endcase
	end

	assign we            = busy_q && fit_q;
	assign waddr         = count_q[AW-1:0];
	assign count         = count_q;
	assign stat.busy     = busy_q;
	assign stat.go       = go_q;
	assign stat.overflow = ovf_q;

endmodule

FILE: rtl/core/bsmh_chain.sv
`timescale 1ns / 1ps
// Chain engine: sequencer around one shared multiply/compare pipeline that
// runs the longest-chain dynamic program. Depends on bsmh_pkg.
module bsmh_chain #(
	parameter int CAP = 96,
	parameter int DW  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [$clog2(CAP+1)-1:0]          n,
	input  logic                              res_take,
	output bsmh_pkg::chain_res_t              res,
	output logic                              busy,
	output logic [$clog2(CAP)-1:0]            o_raddr,
	input  logic [3*DW-1:0]                   o_rdata,
	output logic                              dp_we,
	output logic [$clog2(CAP)-1:0]            dp_waddr,
	output logic [bsmh_pkg::HEIGHT_W:0]       dp_wdata,
	output logic [$clog2(CAP)-1:0]            dp_raddr,
	input  logic [bsmh_pkg::HEIGHT_W:0]       dp_rdata
);
	import bsmh_pkg::*;

	localparam int CW = $clog2(CAP + 1);
	localparam int AW = $clog2(CAP);
	localparam int AR = 2 * DW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_PICK = 3'd2;
	localparam logic [2:0] ST_DOM  = 3'd3;
	localparam logic [2:0] ST_WRB  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]          state_q;
	logic [CW-1:0]       idx_q, rnd_q;
	logic                v_s1, v_s2;
	logic [AW-1:0]       idx_s1, idx_s2;
	logic [AR-1:0]       area_s2;
	logic [DW-1:0]       a_s2, b_s2, h_s2;
	logic                proc_s2;
	logic [HEIGHT_W-1:0] best_s2;
	logic                found_q;
	logic [AW-1:0]       pick_q;
	logic [AR-1:0]       parea_q;
	logic [DW-1:0]       pa_q, pb_q, ph_q;
	logic [HEIGHT_W-1:0] below_q, top_q;
	logic                issue, drained;
	logic [DW-1:0]       rd_h, rd_a, rd_b;
	logic [HEIGHT_W:0]   sum;
	logic [HEIGHT_W-1:0] sat;

	assign issue   = ((state_q == ST_PICK) || (state_q == ST_DOM)) && (idx_q != n);
	assign drained = !issue && !v_s1 && !v_s2;
	assign {rd_h, rd_a, rd_b} = o_rdata;

	assign sum = {1'b0, below_q} + (HEIGHT_W+1)'(ph_q);
	assign sat = sum[HEIGHT_W] ? HEIGHT_MAX : sum[HEIGHT_W-1:0];

	assign o_raddr  = idx_q[AW-1:0];
	assign dp_raddr = idx_q[AW-1:0];
	assign dp_we    = (state_q == ST_CLR) || (state_q == ST_WRB);
	assign dp_waddr = (state_q == ST_WRB) ? pick_q : idx_q[AW-1:0];
	assign dp_wdata = (state_q == ST_WRB) ? {1'b1, sat} : '0;

	// shared unit: read, then multiply into a register, then compare
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q[AW-1:0];
		idx_s2  <= idx_s1;
		area_s2 <= AR'(rd_a) * AR'(rd_b);
		a_s2    <= rd_a;
		b_s2    <= rd_b;
		h_s2    <= rd_h;
		proc_s2 <= dp_rdata[HEIGHT_W];
		best_s2 <= dp_rdata[HEIGHT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			rnd_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
			pick_q  <= '0;
			parea_q <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			ph_q    <= '0;
			below_q <= '0;
			top_q   <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						top_q <= '0;
						idx_q <= '0;
						state_q <= (n == '0) ? ST_OUT : ST_CLR;
					end
				end
				ST_CLR: begin
					// drop processed marks of every stored orientation
					idx_q <= idx_q + CW'(1);
					if ((idx_q + CW'(1)) == n) begin
						idx_q   <= '0;
						rnd_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					// keep the first unprocessed entry of largest base area
					if (v_s2 && !proc_s2 && (!found_q || (area_s2 > parea_q))) begin
						found_q <= 1'b1;
						pick_q  <= idx_s2;
						parea_q <= area_s2;
						pa_q    <= a_s2;
						pb_q    <= b_s2;
						ph_q    <= h_s2;
					end
					if (drained) begin
						idx_q   <= '0;
						below_q <= '0;
						state_q <= ST_DOM;
					end
				end
				ST_DOM: begin
					// tallest processed stack that strictly contains the pick
					if (v_s2 && proc_s2 && (a_s2 > pa_q) && (b_s2 > pb_q) &&
					    (best_s2 > below_q)) begin
						below_q <= best_s2;
					end
					if (drained) begin
						state_q <= ST_WRB;
					end
				end
				ST_WRB: begin
					if (sat > top_q) begin
						top_q <= sat;
					end
					rnd_q <= rnd_q + CW'(1);
					idx_q <= '0;
					found_q <= 1'b0;
					state_q <= ((rnd_q + CW'(1)) == n) ? ST_OUT : ST_PICK;
				end
				ST_OUT: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid  = (state_q == ST_OUT);
	assign res.height = top_q;
	assign busy       = (state_q != ST_IDLE);

endmodule

FILE: rtl/core/box_stack_max_height.sv
`timescale 1ns / 1ps
// Top level of the box stacking block: tallest strictly nested stack.
// Depends on bsmh_pkg, bsmh_ram, bsmh_load and bsmh_chain.
//
// Usage:
//   The box channel (box_valid / box_stall / box) takes one box per beat.
//   Each box holds the input from its accept cycle until its sorted sides are
//   written as three orientations, one per cycle, through the single write
//   port of the orientation RAM. Boxes past 3*MAX_BOXES orientations are
//   dropped and remembered as overflow.
//   A beat with last_box set starts the chain computation over the n stored
//   orientations: one pass clears the processed marks, then n rounds follow,
//   each of two scans (pick the largest base area, then find the best stack
//   it can sit on) plus one write-back.
//   box_stall stays high until that result sits in the output register; the
//   stored set is emptied at that handover.
//   The result channel (result_valid / result_stall / result) carries one beat
//   per set. A stalled result holds and the next set may load meanwhile; its
//   result waits in the engine until the first is taken.
//   Reset (arst_n low) empties the set, clears the overflow flag and drops any
//   pending result; the RAMs need no clearing pass.
module box_stack_max_height #(
	parameter int MAX_BOXES = 32,
	parameter int DIM_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   box_valid,
	output logic                   box_stall,
	input  bsmh_pkg::box_beat_t    box,
	output logic                   result_valid,
	input  logic                   result_stall,
	output bsmh_pkg::result_beat_t result
);
	import bsmh_pkg::*;

	localparam int CAP = 3 * MAX_BOXES;
	localparam int CW  = $clog2(CAP + 1);
	localparam int AW  = $clog2(CAP);
	localparam int DW  = (DIM_BITS < FIELD_W) ? DIM_BITS : FIELD_W;
	localparam int OW  = 3 * DW;

	load_stat_t          ld_stat;
	chain_res_t          res;
	logic [CW-1:0]       count;
	logic                take, res_take, eng_busy;
	logic                o_we;
	logic [AW-1:0]       o_waddr, o_raddr;
	logic [OW-1:0]       o_wdata, o_rdata;
	logic                dp_we;
	logic [AW-1:0]       dp_waddr, dp_raddr;
	logic [HEIGHT_W:0]   dp_wdata, dp_rdata;
	logic                result_valid_q;
	result_beat_t        result_q;

	// accept a box only while neither the loader nor the engine is working
	assign box_stall = ld_stat.busy || ld_stat.go || eng_busy;
	assign take      = box_valid && !box_stall;

	// move the finished height into the output register once it is free
	assign res_take = res.valid && (!result_valid_q || !result_stall);

	bsmh_load #(
		.CAP (CAP),
		.DW  (DW)
	) u_load (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.dx     (box.dim_x[DW-1:0]),
		.dy     (box.dim_y[DW-1:0]),
		.dz     (box.dim_z[DW-1:0]),
		.last   (box.last_box),
		.clear  (res_take),
		.stat   (ld_stat),
		.count  (count),
		.we     (o_we),
		.waddr  (o_waddr),
		.wdata  (o_wdata)
	);

	// orientation store: {height, short side, long side}
	bsmh_ram #(
		.WIDTH (OW),
		.DEPTH (CAP)
	) u_orient_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	// stack store: {processed, best stack height}
	bsmh_ram #(
		.WIDTH (HEIGHT_W + 1),
		.DEPTH (CAP)
	) u_stack_ram (
		.clk   (clk),
		.we    (dp_we),
		.waddr (dp_waddr),
		.wdata (dp_wdata),
		.raddr (dp_raddr),
		.rdata (dp_rdata)
	);

	bsmh_chain #(
		.CAP (CAP),
		.DW  (DW)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ld_stat.go),
		.n        (count),
		.res_take (res_take),
		.res      (res),
		.busy     (eng_busy),
		.o_raddr  (o_raddr),
		.o_rdata  (o_rdata),
		.dp_we    (dp_we),
		.dp_waddr (dp_waddr),
		.dp_wdata (dp_wdata),
		.dp_raddr (dp_raddr),
		.dp_rdata (dp_rdata)
	);

	// output register: hold while stalled, drop once delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			result_q.max_height <= res.height;
			result_q.overflowed <= ld_stat.overflow;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: rtl/core/bsmh_checker.sv
`timescale 1ns / 1ps
// Port-level checker for box_stack_max_height, attached by bind.
// Depends on bsmh_pkg.
module bsmh_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   box_valid,
	input logic                   box_stall,
	input bsmh_pkg::box_beat_t    box,
	input logic                   result_valid,
	input logic                   result_stall,
	input bsmh_pkg::result_beat_t result
);
	import bsmh_pkg::*;

	// a stalled result beat stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat withdrawn while stalled");

	// a stalled result beat keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// an accepted box stalls the box channel in the cycle after it
	a_box_busy: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_stall |=> box_stall)
		else $error("box accepted on back-to-back cycles");

	// a new result appears only out of a busy computation
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(box_stall))
		else $error("result appeared while the block was idle");

endmodule

bind box_stack_max_height bsmh_checker u_bsmh_checker (.*);
